[rtl/rtvc_pkg.sv]
package rtvc_pkg;

  localparam int LogDepth = 1024;
  localparam int IdxW = $clog2(LogDepth);
  localparam int CntW = IdxW + 1;
  localparam int MaxPeers = 4;
  localparam int NumMatch = 4;
  localparam int PeerLim = (MaxPeers < NumMatch) ? MaxPeers : NumMatch;
  localparam int QDepth = 2;

  typedef enum logic [2:0] {
    CMD_APPEND    = 3'd0,
    CMD_CANDIDATE = 3'd1,
    CMD_LEADER    = 3'd2,
    CMD_FOLLOWER  = 3'd3,
    CMD_VOTE      = 3'd4,
    CMD_ADVANCE   = 3'd5,
    CMD_MAJORITY  = 3'd6,
    CMD_BAD       = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ROLE_FOLLOWER  = 2'd0,
    ROLE_CANDIDATE = 2'd1,
    ROLE_LEADER    = 2'd2
  } role_e;

  typedef enum logic [1:0] {
    CFG_SELF_ID = 2'd0,
    CFG_CLUSTER = 2'd1,
    CFG_PEERS   = 2'd2
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAST_RD,
    ST_LAST_WAIT,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_OUT
  } state_e;

  // One classified command as it travels from front to back.
  typedef struct packed {
    cmd_e               cmd;
    logic [31:0]        req_term;
    logic [15:0]        req_node_id;
    logic [CntW-1:0]    cand_last_index;
    logic [31:0]        cand_last_term;
    logic [CntW-1:0]    commit_target;
    logic [NumMatch-1:0][CntW-1:0] match;
  } item_t;

endpackage

[rtl/rtvc_front.sv]
module rtvc_front
  import rtvc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  item_t           in_item_i,
  output logic            q_valid_o,
  input  logic            q_pop_i,
  output item_t           q_item_o
);

  localparam int PtrW = $clog2(QDepth);

  item_t            mem_q [QDepth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  logic             push;
  item_t            cls;

  assign in_stall_o = (cnt_q == (PtrW+1)'(QDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_q];

  // Unknown command codes collapse onto one reject code.
  always_comb begin
    cls = in_item_i;
    if (in_item_i.cmd > CMD_MAJORITY) begin
      cls.cmd = CMD_BAD;
    end
  end

  always_comb begin
    wr_d  = push ? PtrW'(wr_q + 1'b1) : wr_q;
    rd_d  = (q_pop_i && q_valid_o) ? PtrW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop_i && q_valid_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cls;
    end
  end

endmodule

[rtl/rtvc_back.sv]
module rtvc_back
  import rtvc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [15:0]     cfg_data_i,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  input  item_t           q_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            status_o,
  output logic            vote_granted_o,
  output logic [31:0]     term_now_o,
  output logic [1:0]      role_now_o,
  output logic [15:0]     vote_holder_o,
  output logic [CntW-1:0] commit_now_o,
  output logic [CntW-1:0] last_index_now_o,
  output logic [31:0]     last_term_now_o
);

  logic [15:0]     self_q;
  logic [2:0]      clus_q, peers_q;
  logic [31:0]     term_q, term_d;
  logic [15:0]     vote_q, vote_d;
  role_e           role_q, role_d;
  logic [CntW-1:0] commit_q, commit_d;
  logic [CntW-1:0] count_q, count_d;
  logic [31:0]     last_term_q, last_term_d;
  state_e          st_q, st_d;
  item_t           it_q;
  logic [CntW-1:0] walk_q, walk_d;
  logic            ok_q, ok_d, gr_q, gr_d;

  logic [31:0]     ram_q [LogDepth];
  logic [31:0]     rd_data_q;
  logic            ram_we;
  logic            ram_re;
  logic [IdxW-1:0] ram_addr;

  logic [2:0]      n_eff;
  logic [2:0]      quorum;
  logic [3:0]      votes;
  logic [2:0]      peers_eff;
  logic            up_to_date;
  logic [CntW-1:0] tgt;
  logic            take;

  assign take  = (st_q == ST_IDLE) && q_valid_i;
  assign q_pop_o = take;

  always_comb begin
    n_eff     = (clus_q == 3'd0) ? 3'd1 : clus_q;
    quorum    = 3'(n_eff >> 1) + 3'd1;
    peers_eff = (peers_q > 3'(PeerLim)) ? 3'(PeerLim) : peers_q;
    votes     = 4'd1;
    for (int i = 0; i < NumMatch; i++) begin
      if ((3'(i) < peers_eff) && (it_q.match[i] >= walk_q)) begin
        votes = votes + 4'd1;
      end
    end
  end

  always_comb begin
    up_to_date = (it_q.cand_last_term > last_term_q) ||
                 ((it_q.cand_last_term == last_term_q) &&
                  (it_q.cand_last_index >= count_q));
    tgt = (it_q.commit_target > count_q) ? count_q : it_q.commit_target;
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          st_d = ST_LAST_RD;
        end
      end
      ST_LAST_RD: begin
        case (it_q.cmd)
          CMD_APPEND: st_d = (count_q >= CntW'(LogDepth)) ? ST_OUT : ST_LAST_WAIT;
          CMD_MAJORITY: st_d = (count_q > commit_q) ? ST_WALK_RD : ST_OUT;
          default: st_d = ST_OUT;
        endcase
      end
      ST_LAST_WAIT: st_d = ST_OUT;
      ST_WALK_RD: st_d = ST_WALK_CHK;
      ST_WALK_CHK: begin
        if (((rd_data_q == term_q) && ({1'b0, votes} >= {2'b0, quorum})) ||
            (walk_q - 1'b1 <= commit_q)) begin
          st_d = ST_OUT;
        end else begin
          st_d = ST_WALK_RD;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // State updates and RAM access.
  always_comb begin
    term_d = term_q; vote_d = vote_q; role_d = role_q; commit_d = commit_q;
    count_d = count_q; last_term_d = last_term_q; walk_d = walk_q;
    ok_d = ok_q; gr_d = gr_q;
    ram_we = 1'b0; ram_re = 1'b0; ram_addr = '0;
    case (st_q)
      ST_IDLE: begin
        ok_d = 1'b1;
        gr_d = 1'b0;
      end
      ST_LAST_RD: begin
        case (it_q.cmd)
          CMD_APPEND: begin
            if (count_q >= CntW'(LogDepth)) begin
              ok_d = 1'b0;
            end else begin
              ram_we      = 1'b1;
              ram_addr    = count_q[IdxW-1:0];
              count_d     = count_q + 1'b1;
              last_term_d = term_q;
            end
          end
          CMD_CANDIDATE: begin
            if (term_q == 32'hFFFF_FFFF) begin
              ok_d = 1'b0;
            end else begin
              term_d = term_q + 32'd1;
              role_d = ROLE_CANDIDATE;
              vote_d = self_q;
            end
          end
          CMD_LEADER: begin
            if (role_q != ROLE_CANDIDATE) ok_d = 1'b0;
            else role_d = ROLE_LEADER;
          end
          CMD_FOLLOWER: begin
            if (it_q.req_term < term_q) begin
              ok_d = 1'b0;
            end else begin
              if (it_q.req_term > term_q) begin
                term_d = it_q.req_term;
                vote_d = '0;
              end
              role_d = ROLE_FOLLOWER;
            end
          end
          CMD_VOTE: begin
            if (it_q.req_term >= term_q) begin
              if (it_q.req_term > term_q) begin
                term_d = it_q.req_term;
                role_d = ROLE_FOLLOWER;
              end
              if (((it_q.req_term > term_q) || (vote_q == '0) ||
                   (vote_q == it_q.req_node_id)) && up_to_date) begin
                vote_d = it_q.req_node_id;
                role_d = ROLE_FOLLOWER;
                gr_d   = 1'b1;
              end else if (it_q.req_term > term_q) begin
                vote_d = '0;
              end
            end
          end
          CMD_ADVANCE: begin
            if (tgt < commit_q) ok_d = 1'b0;
            else commit_d = tgt;
          end
          CMD_MAJORITY: walk_d = count_q;
          default: ok_d = 1'b0;
        endcase
      end
      ST_WALK_RD: begin
        ram_re   = 1'b1;
        ram_addr = IdxW'(walk_q - 1'b1);
      end
      ST_WALK_CHK: begin
        if ((rd_data_q == term_q) && ({1'b0, votes} >= {2'b0, quorum})) begin
          commit_d = walk_q;
        end else begin
          walk_d = walk_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      ram_q[ram_addr] <= term_q;
    end
    if (ram_re) begin
      rd_data_q <= ram_q[ram_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      it_q <= q_item_i;
    end
    walk_q <= walk_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_q <= 16'd1; clus_q <= 3'd1; peers_q <= 3'd0;
      term_q <= '0; vote_q <= '0; role_q <= ROLE_FOLLOWER;
      commit_q <= '0; count_q <= '0; last_term_q <= '0;
      st_q <= ST_IDLE; ok_q <= 1'b1; gr_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SELF_ID: self_q  <= cfg_data_i;
          CFG_CLUSTER: clus_q  <= cfg_data_i[2:0];
          CFG_PEERS:   peers_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      term_q <= term_d; vote_q <= vote_d; role_q <= role_d;
      commit_q <= commit_d; count_q <= count_d; last_term_q <= last_term_d;
      st_q <= st_d; ok_q <= ok_d; gr_q <= gr_d;
    end
  end

  assign out_valid_o      = (st_q == ST_OUT);
  assign status_o         = !ok_q;
  assign vote_granted_o   = gr_q;
  assign term_now_o       = term_q;
  assign role_now_o       = role_q;
  assign vote_holder_o    = vote_q;
  assign commit_now_o     = commit_q;
  assign last_index_now_o = count_q;
  assign last_term_now_o  = last_term_q;

endmodule

[rtl/raft_term_vote_commit_engine_core.sv]
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_stall_o   | cmd_i .. match_3_i
// out     | output    | out_valid_o / out_stall_i | status_o .. last_term_now_o
// cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// A command passes through the back end's ST_IDLE, ST_LAST_RD and ST_OUT states,
// then waits on the output handshake; an append that fits also passes ST_LAST_WAIT.
// A majority commit walks the log from the last index down, through ST_WALK_RD
// and ST_WALK_CHK per entry in the single-port log RAM. A two-entry queue lets
// the front take items while the back works. Reset clears all control state;
// the log RAM is not cleared since only written entries are ever read.
module raft_term_vote_commit_engine_core
  import rtvc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [15:0]     cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [2:0]      cmd_i,
  input  logic [31:0]     req_term_i,
  input  logic [15:0]     req_node_id_i,
  input  logic [10:0]     cand_last_index_i,
  input  logic [31:0]     cand_last_term_i,
  input  logic [10:0]     commit_target_i,
  input  logic [10:0]     match_0_i,
  input  logic [10:0]     match_1_i,
  input  logic [10:0]     match_2_i,
  input  logic [10:0]     match_3_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            status_o,
  output logic            vote_granted_o,
  output logic [31:0]     term_now_o,
  output logic [1:0]      role_now_o,
  output logic [15:0]     vote_holder_o,
  output logic [10:0]     commit_now_o,
  output logic [10:0]     last_index_now_o,
  output logic [31:0]     last_term_now_o
);

  item_t in_item, q_item;
  logic  q_valid, q_pop;

  // Pack the input fields into one item for the queue.
  always_comb begin
    in_item.cmd             = cmd_e'(cmd_i);
    in_item.req_term        = req_term_i;
    in_item.req_node_id     = req_node_id_i;
    in_item.cand_last_index = cand_last_index_i;
    in_item.cand_last_term  = cand_last_term_i;
    in_item.commit_target   = commit_target_i;
    in_item.match[0]        = match_0_i;
    in_item.match[1]        = match_1_i;
    in_item.match[2]        = match_2_i;
    in_item.match[3]        = match_3_i;
  end

  rtvc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  rtvc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .q_valid_i        (q_valid),
    .q_pop_o          (q_pop),
    .q_item_i         (q_item),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .vote_granted_o   (vote_granted_o),
    .term_now_o       (term_now_o),
    .role_now_o       (role_now_o),
    .vote_holder_o    (vote_holder_o),
    .commit_now_o     (commit_now_o),
    .last_index_now_o (last_index_now_o),
    .last_term_now_o  (last_term_now_o)
  );

endmodule
